// File: rtl/core/vvpu_pkg.sv
// ============================================================================
// vvpu_pkg
// Shared types, field widths and fixed-point constants of the velocity
// Verlet particle update unit.
// ============================================================================
package vvpu_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned MASS_W   = 16;
    localparam int unsigned DT_W     = 15;
    localparam int unsigned CAP_W    = 31;
    localparam int unsigned ENERGY_W = 48;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned ADDR_W   = 1;

    // Kick quotient: a Q16.16 derivative times a Q4.12 step times the kick
    // constant, shifted right by 32, is at most 35 bits wide.
    localparam int unsigned DIVD_W = 35;
    localparam int unsigned CNT_W  = $clog2(DIVD_W);

    localparam logic [DT_W-1:0]     DT_MAX = 15'd16384;
    // 2.0934e-4 in Q0.32.
    localparam logic [19:0]         KICK_K = 20'd899108;
    // 0.5 / 4.1868e-4 in Q12.12.
    localparam logic [22:0]         KE_K   = 23'd4891564;
    localparam logic [ENERGY_W-1:0] E_MAX  = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_KICK_DRIFT = 2'd0,
        CMD_KICK       = 2'd1,
        CMD_ENERGY     = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    typedef enum logic [ADDR_W-1:0] {
        REG_TIME_STEP = 1'b0,
        REG_VEL_CAP   = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_K_MUL_A,
        ST_K_MUL_HI,
        ST_K_MUL_LO,
        ST_K_SUM,
        ST_K_DIV,
        ST_CLAMP,
        ST_D_MUL,
        ST_D_ADD,
        ST_E_SQ,
        ST_E_ACC,
        ST_E_MLO,
        ST_E_MHI,
        ST_E_P,
        ST_E_KH,
        ST_E_KL,
        ST_E_C,
        ST_E_SUM,
        ST_DONE
    } state_t;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage

// File: rtl/core/velocity_verlet_particle_update_unit.sv
// ============================================================================
// velocity_verlet_particle_update_unit
// Fixed-point velocity Verlet step for one particle per input beat.
// ============================================================================
// Usage:
//   The slave channel takes one particle per beat: mass, position, force
//   derivative and velocity in s_tdata, command and first-of-sum flag in
//   s_tuser. The master channel returns one beat per particle with the new
//   velocity, the new position and the running kinetic energy.
//   Configuration (time step, velocity cap) is written through cfg_wr_en,
//   cfg_addr and cfg_wdata while no particle is in flight.
//   One particle is processed at a time; s_tready is high only while idle.
//   A shared 32x32 multiplier and a one-bit-per-cycle divider do all the
//   arithmetic under a sequencer, and the 35-step mass division dominates.
//   Kick and drift kicks, clamps and drifts each component in turn, and
//   kick only kicks them; energy squares and sums the components; no-op goes
//   to the final step. A new particle can be accepted as m_tvalid rises.
//   The result sits in an output register, so a stalled receiver does not
//   keep the next particle from being accepted; the sequencer only waits
//   at its final step while the previous result is still held.
//   Reset clears the energy sum, sets a 4.0 fs step and the largest cap.
// ============================================================================
module velocity_verlet_particle_update_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // mass[15:0], pos_x, pos_y, pos_z, grad_x, grad_y, grad_z,
    // vel_x, vel_y, vel_z (32 bits each, from bit 16 up)
    input  logic [303:0]                        s_tdata,
    // command[1:0], first_of_sum[2]
    input  logic [2:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // new_vel_x, new_vel_y, new_vel_z, new_pos_x, new_pos_y, new_pos_z
    // (32 bits each), kinetic_energy[239:192]
    output logic [239:0]                        m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [vvpu_pkg::ADDR_W-1:0]         cfg_addr,
    input  logic [vvpu_pkg::CAP_W-1:0]          cfg_wdata
);

    localparam int unsigned W = vvpu_pkg::DATA_W;

    vvpu_pkg::state_t state_reg, state_next;

    logic [vvpu_pkg::DT_W-1:0]      ts_reg;
    logic [vvpu_pkg::CAP_W-1:0]     cap_reg;
    logic [vvpu_pkg::ENERGY_W-1:0]  energy_reg;

    vvpu_pkg::cmd_t                 cmd_reg;
    logic                           first_reg;
    logic [vvpu_pkg::MASS_W-1:0]    mass_reg;
    logic [W-1:0]                   pos_reg  [3];
    logic [W-1:0]                   grad_reg [3];
    logic [W-1:0]                   vel_reg  [3];
    logic [1:0]                     j_reg;

    logic [25:0]                    alo_reg;
    logic [39:0]                    xhi_reg;
    logic [63:0]                    s_reg;
    logic [47:0]                    plo_reg;
    logic [55:0]                    p_reg;
    logic [54:0]                    chi_reg;
    logic [vvpu_pkg::ENERGY_W-1:0]  c_reg;

    logic [239:0]                   out_reg;
    logic                           out_valid_reg;

    logic [W-1:0]                   mul_a;
    logic [W-1:0]                   mul_b;
    logic [2*W-1:0]                 prod;
    logic                           div_start;
    logic [vvpu_pkg::DIVD_W-1:0]    div_q;
    logic                           div_done;

    logic [vvpu_pkg::DT_W-1:0]      dt;
    logic [W-1:0]                   cur_vel;
    logic [W-1:0]                   cur_pos;
    logic [W-1:0]                   cur_grad;
    logic [50:0]                    kick_x;
    logic [36:0]                    kick_sum;
    logic [W-1:0]                   kick_vel;
    logic signed [W-1:0]            cap_pos;
    logic signed [W-1:0]            cap_neg;
    logic [W-1:0]                   clamp_vel;
    logic [33:0]                    drift_d;
    logic [33:0]                    drift_sum;
    logic [W-1:0]                   drift_pos;
    logic [55:0]                    ke_c;
    logic [vvpu_pkg::ENERGY_W:0]    esum;
    logic                           out_free;
    logic                           s_accept;

    assign dt       = (ts_reg > vvpu_pkg::DT_MAX) ? vvpu_pkg::DT_MAX : ts_reg;
    assign cur_vel  = vel_reg[j_reg];
    assign cur_pos  = pos_reg[j_reg];
    assign cur_grad = grad_reg[j_reg];
    assign out_free = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    vvpu_mul u_mul (
        .aclk  (aclk),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (prod)
    );

    vvpu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (kick_x[50:16]),
        .divisor  (mass_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    // ------------------------------------------------------------------
    // Datapath arithmetic around the shared units
    // ------------------------------------------------------------------
    always_comb begin
        // Kick term before the mass division: (hi * K) << 10 plus
        // (lo * K) >> 16, with the final >> 16 taken by the part-select.
        kick_x = {1'b0, xhi_reg, 10'b0} + 51'(prod[45:16]);

        // The kick opposes the derivative.
        if (cur_grad[W-1]) begin
            kick_sum = {{5{cur_vel[W-1]}}, cur_vel} + {2'b0, div_q};
        end else begin
            kick_sum = {{5{cur_vel[W-1]}}, cur_vel} - {2'b0, div_q};
        end
        if (kick_sum[36:31] == 6'b000000 || kick_sum[36:31] == 6'b111111) begin
            kick_vel = kick_sum[W-1:0];
        end else if (kick_sum[36]) begin
            kick_vel = 32'h8000_0000;
        end else begin
            kick_vel = 32'h7FFF_FFFF;
        end

        cap_pos = signed'({1'b0, cap_reg});
        cap_neg = -cap_pos;
        if (signed'(cur_vel) > cap_pos) begin
            clamp_vel = cap_pos;
        end else if (signed'(cur_vel) < cap_neg) begin
            clamp_vel = cap_neg;
        end else begin
            clamp_vel = cur_vel;
        end

        // Drift magnitude truncates toward zero, then takes the sign of v.
        drift_d = {7'b0, prod[46:20]};
        if (cur_vel[W-1]) begin
            drift_d = ~drift_d + 34'd1;
        end
        drift_sum = {{2{cur_pos[W-1]}}, cur_pos} + drift_d;
        if (drift_sum[33:31] == 3'b000 || drift_sum[33:31] == 3'b111) begin
            drift_pos = drift_sum[W-1:0];
        end else if (drift_sum[33]) begin
            drift_pos = 32'h8000_0000;
        end else begin
            drift_pos = 32'h7FFF_FFFF;
        end

        ke_c = {1'b0, chi_reg} + 56'(prod[46:24]);

        esum = {1'b0, (first_reg ? '0 : energy_reg)} + {1'b0, c_reg};
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vvpu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            vvpu_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (vvpu_pkg::cmd_t'(s_tuser[1:0]))
                        vvpu_pkg::CMD_KICK_DRIFT,
                        vvpu_pkg::CMD_KICK:   state_next = vvpu_pkg::ST_K_MUL_A;
                        vvpu_pkg::CMD_ENERGY: state_next = vvpu_pkg::ST_E_SQ;
                        default:              state_next = vvpu_pkg::ST_DONE;
                    endcase
                end
            end
            vvpu_pkg::ST_K_MUL_A: begin
                mul_a      = vvpu_pkg::mag32(cur_grad);
                mul_b      = W'(dt);
                state_next = vvpu_pkg::ST_K_MUL_HI;
            end
            vvpu_pkg::ST_K_MUL_HI: begin
                mul_a      = W'(prod[45:26]);
                mul_b      = W'(vvpu_pkg::KICK_K);
                state_next = vvpu_pkg::ST_K_MUL_LO;
            end
            vvpu_pkg::ST_K_MUL_LO: begin
                mul_a      = W'(alo_reg);
                mul_b      = W'(vvpu_pkg::KICK_K);
                state_next = vvpu_pkg::ST_K_SUM;
            end
            vvpu_pkg::ST_K_SUM: begin
                div_start  = 1'b1;
                state_next = vvpu_pkg::ST_K_DIV;
            end
            vvpu_pkg::ST_K_DIV: begin
                if (div_done) begin
                    if (cmd_reg == vvpu_pkg::CMD_KICK_DRIFT) begin
                        state_next = vvpu_pkg::ST_CLAMP;
                    end else if (j_reg == 2'd2) begin
                        state_next = vvpu_pkg::ST_DONE;
                    end else begin
                        state_next = vvpu_pkg::ST_K_MUL_A;
                    end
                end
            end
            vvpu_pkg::ST_CLAMP: begin
                state_next = vvpu_pkg::ST_D_MUL;
            end
            vvpu_pkg::ST_D_MUL: begin
                mul_a      = vvpu_pkg::mag32(cur_vel);
                mul_b      = W'(dt);
                state_next = vvpu_pkg::ST_D_ADD;
            end
            vvpu_pkg::ST_D_ADD: begin
                state_next = (j_reg == 2'd2) ? vvpu_pkg::ST_DONE : vvpu_pkg::ST_K_MUL_A;
            end
            vvpu_pkg::ST_E_SQ: begin
                mul_a      = vvpu_pkg::mag32(cur_vel);
                mul_b      = vvpu_pkg::mag32(cur_vel);
                state_next = vvpu_pkg::ST_E_ACC;
            end
            vvpu_pkg::ST_E_ACC: begin
                state_next = (j_reg == 2'd2) ? vvpu_pkg::ST_E_MLO : vvpu_pkg::ST_E_SQ;
            end
            vvpu_pkg::ST_E_MLO: begin
                mul_a      = s_reg[55:24];
                mul_b      = W'(mass_reg);
                state_next = vvpu_pkg::ST_E_MHI;
            end
            vvpu_pkg::ST_E_MHI: begin
                mul_a      = W'(s_reg[63:56]);
                mul_b      = W'(mass_reg);
                state_next = vvpu_pkg::ST_E_P;
            end
            vvpu_pkg::ST_E_P: begin
                state_next = vvpu_pkg::ST_E_KH;
            end
            vvpu_pkg::ST_E_KH: begin
                mul_a      = p_reg[55:24];
                mul_b      = W'(vvpu_pkg::KE_K);
                state_next = vvpu_pkg::ST_E_KL;
            end
            vvpu_pkg::ST_E_KL: begin
                mul_a      = W'(p_reg[23:0]);
                mul_b      = W'(vvpu_pkg::KE_K);
                state_next = vvpu_pkg::ST_E_C;
            end
            vvpu_pkg::ST_E_C: begin
                state_next = vvpu_pkg::ST_E_SUM;
            end
            vvpu_pkg::ST_E_SUM: begin
                state_next = vvpu_pkg::ST_DONE;
            end
            vvpu_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = vvpu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vvpu_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Particle registers and intermediate results
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg     <= vvpu_pkg::cmd_t'(s_tuser[1:0]);
            first_reg   <= s_tuser[2];
            mass_reg    <= (s_tdata[15:0] == '0) ? 16'd1 : s_tdata[15:0];
            pos_reg[0]  <= s_tdata[47:16];
            pos_reg[1]  <= s_tdata[79:48];
            pos_reg[2]  <= s_tdata[111:80];
            grad_reg[0] <= s_tdata[143:112];
            grad_reg[1] <= s_tdata[175:144];
            grad_reg[2] <= s_tdata[207:176];
            vel_reg[0]  <= s_tdata[239:208];
            vel_reg[1]  <= s_tdata[271:240];
            vel_reg[2]  <= s_tdata[303:272];
            j_reg       <= 2'd0;
            s_reg       <= '0;
        end
        case (state_reg)
            vvpu_pkg::ST_K_MUL_HI: alo_reg <= prod[25:0];
            vvpu_pkg::ST_K_MUL_LO: xhi_reg <= prod[39:0];
            vvpu_pkg::ST_K_DIV: begin
                if (div_done) begin
                    vel_reg[j_reg] <= kick_vel;
                    if (cmd_reg != vvpu_pkg::CMD_KICK_DRIFT) begin
                        j_reg <= j_reg + 2'd1;
                    end
                end
            end
            vvpu_pkg::ST_CLAMP: vel_reg[j_reg] <= clamp_vel;
            vvpu_pkg::ST_D_ADD: begin
                pos_reg[j_reg] <= drift_pos;
                j_reg          <= j_reg + 2'd1;
            end
            vvpu_pkg::ST_E_ACC: begin
                s_reg <= s_reg + prod;
                j_reg <= j_reg + 2'd1;
            end
            vvpu_pkg::ST_E_MHI: plo_reg <= prod[47:0];
            vvpu_pkg::ST_E_P:   p_reg   <= {8'b0, plo_reg} + {prod[23:0], 32'b0};
            vvpu_pkg::ST_E_KL:  chi_reg <= prod[54:0];
            vvpu_pkg::ST_E_C: begin
                c_reg <= (ke_c > 56'(vvpu_pkg::E_MAX)) ? vvpu_pkg::E_MAX : ke_c[47:0];
            end
            default: begin
            end
        endcase
    end

    // Running kinetic energy sum, saturating.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= '0;
        end else if (state_reg == vvpu_pkg::ST_E_SUM) begin
            energy_reg <= esum[vvpu_pkg::ENERGY_W] ? vvpu_pkg::E_MAX
                                                   : esum[vvpu_pkg::ENERGY_W-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg  <= vvpu_pkg::DT_MAX;
            cap_reg <= '1;
        end else if (cfg_wr_en) begin
            case (vvpu_pkg::reg_idx_t'(cfg_addr))
                vvpu_pkg::REG_TIME_STEP: ts_reg  <= cfg_wdata[vvpu_pkg::DT_W-1:0];
                vvpu_pkg::REG_VEL_CAP:   cap_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == vvpu_pkg::ST_DONE && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == vvpu_pkg::ST_DONE && out_free) begin
            out_reg <= {energy_reg, pos_reg[2], pos_reg[1], pos_reg[0],
                        vel_reg[2], vel_reg[1], vel_reg[0]};
        end
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_valid_reg;

endmodule

// File: rtl/core/vvpu_mul.sv
// ============================================================================
// vvpu_mul
// Shared 32 x 32 unsigned multiplier with a registered product; the result
// of the operands presented in one cycle is available in the next.
// ============================================================================
module vvpu_mul (
    input  logic                            aclk,
    input  logic [vvpu_pkg::DATA_W-1:0]     op_a,
    input  logic [vvpu_pkg::DATA_W-1:0]     op_b,
    output logic [2*vvpu_pkg::DATA_W-1:0]   prod
);

    logic [2*vvpu_pkg::DATA_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/vvpu_div.sv
// ============================================================================
// vvpu_div
// Restoring unsigned divider, one quotient bit per cycle. The kick magnitude
// is the scaled kick term divided by the particle mass.
// ============================================================================
module vvpu_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [vvpu_pkg::DIVD_W-1:0]     dividend,
    input  logic [vvpu_pkg::MASS_W-1:0]     divisor,
    output logic [vvpu_pkg::DIVD_W-1:0]     quotient,
    output logic                            done
);

    localparam int unsigned DW = vvpu_pkg::DIVD_W;
    localparam int unsigned MW = vvpu_pkg::MASS_W;

    logic [DW-1:0]              quo_reg;
    logic [DW-1:0]              quo_next;
    logic [MW-1:0]              rem_reg;
    logic [MW-1:0]              rem_next;
    logic [MW-1:0]              dsr_reg;
    logic [vvpu_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [MW:0]                trial;
    logic                       fits;

    // The dividend shifts out of the top of quo_reg while quotient bits
    // enter at the bottom.
    always_comb begin
        trial    = {rem_reg, quo_reg[DW-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? MW'(trial - {1'b0, dsr_reg}) : trial[MW-1:0];
        quo_next = {quo_reg[DW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
            cnt_reg <= vvpu_pkg::CNT_W'(DW - 1);
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: tb/velocity_verlet_particle_update_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// velocity_verlet_particle_update_unit_tb
// Self-checking bench for the particle update unit. Particles go in on the
// slave stream with random gaps, and results come back under random
// back-pressure. Each accepted particle is run through an integer model of
// the half kick, clamp, drift and kinetic energy sum. Each result beat is
// compared field by field with the oldest prediction.
// ============================================================================
module velocity_verlet_particle_update_unit_tb;

    typedef longint unsigned u64_t;

    localparam int unsigned DW = vvpu_pkg::DATA_W;
    localparam int unsigned MW = vvpu_pkg::MASS_W;
    localparam int unsigned EW = vvpu_pkg::ENERGY_W;
    localparam int unsigned CW = vvpu_pkg::CAP_W;

    localparam u64_t KICK_GAIN   = 64'd899108;    // 2.0934e-4 in Q0.32
    localparam u64_t KE_GAIN     = 64'd4891564;   // 0.5 / 4.1868e-4 in Q12.12
    localparam u64_t STEP_LIMIT  = 64'd16384;     // 4.0 fs in Q4.12
    localparam u64_t ENERGY_CEIL = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic               first;
        vvpu_pkg::cmd_t     command;
        logic [2:0][DW-1:0] vel;
        logic [2:0][DW-1:0] grad;
        logic [2:0][DW-1:0] pos;
        logic [MW-1:0]      mass;
    } particle_t;

    typedef struct packed {
        logic [EW-1:0]      energy;
        logic [2:0][DW-1:0] pos;
        logic [2:0][DW-1:0] vel;
    } update_t;

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic [303:0]                  s_tdata   = '0;
    logic [2:0]                    s_tuser   = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [239:0]                  m_tdata;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [vvpu_pkg::ADDR_W-1:0]   cfg_addr  = '0;
    logic [CW-1:0]                 cfg_wdata = '0;

    // Model copy of the registers and of the running energy sum.
    u64_t step_reg   = 64'd16384;
    u64_t cap_reg    = 64'h7FFF_FFFF;
    u64_t energy_acc = 64'd0;

    update_t     pending_updates[$];
    int          error_count   = 0;
    int unsigned sink_hold_req = 0;
    bit          src_steady    = 1'b0;
    bit          sink_steady   = 1'b0;

    velocity_verlet_particle_update_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint widen(logic [DW-1:0] w);
        return longint'($signed(w));
    endfunction

    function automatic u64_t magnitude(longint v);
        u64_t r;
        r = (v < 0) ? u64_t'(-v) : u64_t'(v);
        return r;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // The kick opposes the derivative and truncates toward zero.
    function automatic longint kick_delta(longint g, u64_t dt, u64_t m);
        u64_t a, x, q;
        a = magnitude(g) * dt;
        x = (((a >> 26) * KICK_GAIN) << 10) + (((a & 64'h3FF_FFFF) * KICK_GAIN) >> 16);
        q = x / (m << 16);
        return (g < 0) ? longint'(q) : -longint'(q);
    endfunction

    // Q8.24 times Q4.12 gives Q12.36; 20 bits are dropped toward zero.
    function automatic longint drift_delta(longint v, u64_t dt);
        longint p;
        u64_t   d;
        p = v * longint'(dt);
        d = magnitude(p) >> 20;
        return (p < 0) ? -longint'(d) : longint'(d);
    endfunction

    function automatic update_t integrate_particle(particle_t p);
        update_t u;
        u64_t    m, dt, sq, prod, gain;
        longint  v, q, cap;
        int      j;
        m   = (p.mass == '0) ? 64'd1 : u64_t'(p.mass);
        dt  = (step_reg > STEP_LIMIT) ? STEP_LIMIT : step_reg;
        cap = longint'(cap_reg);
        u.vel = p.vel;
        u.pos = p.pos;
        case (p.command)
            vvpu_pkg::CMD_KICK_DRIFT, vvpu_pkg::CMD_KICK: begin
                for (j = 0; j < 3; j++) begin
                    v = sat32(widen(p.vel[j]) + kick_delta(widen(p.grad[j]), dt, m));
                    if (p.command == vvpu_pkg::CMD_KICK_DRIFT) begin
                        if (v > cap) v = cap;
                        if (v < -cap) v = -cap;
                        q = sat32(widen(p.pos[j]) + drift_delta(v, dt));
                        u.pos[j] = q[DW-1:0];
                    end
                    u.vel[j] = v[DW-1:0];
                end
            end
            vvpu_pkg::CMD_ENERGY: begin
                sq = 0;
                for (j = 0; j < 3; j++) begin
                    sq += magnitude(widen(p.vel[j])) * magnitude(widen(p.vel[j]));
                end
                prod = m * (sq >> 24);
                gain = (prod >> 24) * KE_GAIN + (((prod & 64'hFF_FFFF) * KE_GAIN) >> 24);
                if (gain > ENERGY_CEIL) gain = ENERGY_CEIL;
                if (p.first) energy_acc = 0;
                energy_acc += gain;
                if (energy_acc > ENERGY_CEIL) energy_acc = ENERGY_CEIL;
            end
            default: ;
        endcase
        u.energy = energy_acc[EW-1:0];
        return u;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 120);
    endfunction

    function automatic logic [DW-1:0] random_word();
        logic [DW-1:0] w;
        int unsigned   sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0, 1: w = $urandom;
            2: w = $urandom_range(0, 32'h0010_0000);
            3, 4: w = $urandom_range(0, 32'h0200_0000);
            default: begin
                case ($urandom_range(0, 3))
                    0: w = 32'h7FFF_FFFF;
                    1: w = 32'h8000_0000;
                    2: w = '0;
                    default: w = 32'h0000_0001;
                endcase
            end
        endcase
        if (sel >= 2 && $urandom_range(0, 1) == 1) w = -w;
        return w;
    endfunction

    function automatic particle_t random_particle();
        particle_t   p;
        int unsigned r;
        int          j;
        r = $urandom_range(0, 99);
        if (r < 40) p.command = vvpu_pkg::CMD_KICK_DRIFT;
        else if (r < 65) p.command = vvpu_pkg::CMD_KICK;
        else if (r < 92) p.command = vvpu_pkg::CMD_ENERGY;
        else p.command = vvpu_pkg::CMD_NOP;
        p.first = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 3))
            0: p.mass = MW'($urandom_range(0, 16));
            1: p.mass = MW'($urandom);
            2: p.mass = MW'($urandom_range(16, 3200));
            default: p.mass = MW'($urandom_range(65280, 65535));
        endcase
        for (j = 0; j < 3; j++) begin
            p.pos[j]  = random_word();
            p.grad[j] = random_word();
            p.vel[j]  = random_word();
        end
        return p;
    endfunction

    function automatic particle_t uniform_particle(vvpu_pkg::cmd_t cmd,
            logic [MW-1:0] mass, logic [DW-1:0] pos, logic [DW-1:0] grad,
            logic [DW-1:0] vel, logic first);
        particle_t p;
        p.command = cmd;
        p.mass    = mass;
        p.first   = first;
        p.pos     = {3{pos}};
        p.grad    = {3{grad}};
        p.vel     = {3{vel}};
        return p;
    endfunction

    // Valid stays high after a beat so that back-to-back beats need no drop.
    task automatic send_particle(input particle_t p);
        int unsigned gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.vel, p.grad, p.pos, p.mass};
        s_tuser  <= {p.first, p.command};
        do @(posedge aclk); while (!s_tready);
        pending_updates.push_back(integrate_particle(p));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input vvpu_pkg::reg_idx_t idx, input logic [CW-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == vvpu_pkg::REG_TIME_STEP) step_reg = u64_t'(value[vvpu_pkg::DT_W-1:0]);
        else cap_reg = u64_t'(value);
    endtask

    task automatic test_field_extremes();
        particle_t p;
        send_particle(uniform_particle(vvpu_pkg::CMD_KICK_DRIFT, 16'd0, 32'h0,
                                       32'h7FFF_FFFF, 32'h0, 1'b1));
        send_particle(uniform_particle(vvpu_pkg::CMD_KICK_DRIFT, 16'd1, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        send_particle(uniform_particle(vvpu_pkg::CMD_KICK_DRIFT, 16'hFFFF, 32'h8000_0000,
                                       32'h1, 32'h8000_0000, 1'b0));
        send_particle(uniform_particle(vvpu_pkg::CMD_KICK, 16'd1, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        send_particle(uniform_particle(vvpu_pkg::CMD_KICK, 16'hFFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1));
        send_particle(uniform_particle(vvpu_pkg::CMD_NOP, 16'hFFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_particle(uniform_particle(vvpu_pkg::CMD_NOP, 16'd0, 32'h0, 32'h0, 32'h0,
                                       1'b0));
        // Mixed signs across the three axes.
        p = uniform_particle(vvpu_pkg::CMD_KICK_DRIFT, 16'd12, 32'h0001_0000, 32'h0,
                             32'h0, 1'b0);
        p.grad[0] = 32'h0100_0000;
        p.grad[1] = 32'hFF00_0000;
        p.vel[2]  = 32'hFFF0_0000;
        send_particle(p);
    endtask

    task automatic test_time_step_limits();
        logic [CW-1:0] steps [4] = '{31'd0, 31'd1, 31'h7FFF, 31'd16384};
        particle_t     p;
        int            k;
        for (k = 0; k < 4; k++) begin
            wait_results_drained();
            write_register(vvpu_pkg::REG_TIME_STEP, steps[k]);
            p = random_particle();
            p.command = vvpu_pkg::CMD_KICK_DRIFT;
            p.mass    = 16'd1;
            send_particle(p);
        end
    endtask

    task automatic test_velocity_cap_limits();
        logic [CW-1:0] caps [4] = '{31'd0, 31'd1, 31'h0100_0000, 31'h7FFF_FFFF};
        particle_t     p;
        int            k;
        for (k = 0; k < 4; k++) begin
            wait_results_drained();
            write_register(vvpu_pkg::REG_VEL_CAP, caps[k]);
            p = random_particle();
            p.command = vvpu_pkg::CMD_KICK_DRIFT;
            p.mass    = 16'd16;
            send_particle(p);
        end
    endtask

    task automatic test_energy_sum_restart();
        send_particle(uniform_particle(vvpu_pkg::CMD_ENERGY, 16'd16, 32'h0, 32'h0,
                                       32'h0100_0000, 1'b1));
        send_particle(uniform_particle(vvpu_pkg::CMD_ENERGY, 16'd200, 32'h0, 32'h0,
                                       32'hFF00_0000, 1'b0));
        // The restart flag means nothing outside an energy beat.
        send_particle(uniform_particle(vvpu_pkg::CMD_KICK, 16'd16, 32'h0, 32'h0001_0000,
                                       32'h0, 1'b1));
        send_particle(uniform_particle(vvpu_pkg::CMD_ENERGY, 16'hFFFF, 32'h0, 32'h0,
                                       32'h8000_0000, 1'b0));
        send_particle(uniform_particle(vvpu_pkg::CMD_ENERGY, 16'd1, 32'h0, 32'h0, 32'h1,
                                       1'b0));
        send_particle(uniform_particle(vvpu_pkg::CMD_ENERGY, 16'd0, 32'h0, 32'h0,
                                       32'h7FFF_FFFF, 1'b1));
    endtask

    // The sink holds off long enough for the block to fill and refuse input.
    task automatic test_output_backpressure();
        int k;
        wait_results_drained();
        src_steady    = 1'b1;
        sink_hold_req = 800;
        for (k = 0; k < 8; k++) send_particle(random_particle());
        src_steady = 1'b0;
        wait_results_drained();
        for (k = 0; k < 4; k++) send_particle(random_particle());
    endtask

    task automatic test_random_traffic();
        int phase, k;
        for (phase = 0; phase < 6; phase++) begin
            wait_results_drained();
            case (phase)
                0: begin
                    write_register(vvpu_pkg::REG_TIME_STEP, 31'd16384);
                    write_register(vvpu_pkg::REG_VEL_CAP, 31'h7FFF_FFFF);
                end
                1: begin
                    write_register(vvpu_pkg::REG_TIME_STEP, 31'd1);
                    write_register(vvpu_pkg::REG_VEL_CAP, CW'($urandom));
                end
                2: begin
                    write_register(vvpu_pkg::REG_TIME_STEP, 31'h7FFF);
                    write_register(vvpu_pkg::REG_VEL_CAP, 31'h7FFF_FFFF);
                end
                3: begin
                    write_register(vvpu_pkg::REG_TIME_STEP, CW'($urandom_range(1, 16384)));
                    write_register(vvpu_pkg::REG_VEL_CAP,
                                   CW'($urandom_range(0, 32'h0400_0000)));
                end
                4: begin
                    // Bits above the time step width are written too.
                    write_register(vvpu_pkg::REG_TIME_STEP, CW'($urandom));
                    write_register(vvpu_pkg::REG_VEL_CAP, CW'($urandom));
                end
                default: begin
                    write_register(vvpu_pkg::REG_TIME_STEP, CW'($urandom_range(1, 4096)));
                    write_register(vvpu_pkg::REG_VEL_CAP,
                                   CW'($urandom_range(0, 32'h0100_0000)));
                end
            endcase
            src_steady  = (phase == 2);
            sink_steady = (phase == 2);
            for (k = 0; k < 90; k++) send_particle(random_particle());
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial begin
        int unsigned stall;
        forever begin
            @(posedge aclk);
            if (sink_hold_req != 0) begin
                stall         = sink_hold_req;
                sink_hold_req = 0;
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void compare_field(string name, logic [EW-1:0] want,
                                          logic [EW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        update_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_updates.size() == 0) begin
                $error("result beat with no particle outstanding: %h", m_tdata);
                error_count++;
            end else begin
                want = pending_updates.pop_front();
                compare_field("new_vel_x", EW'(want.vel[0]), EW'(got.vel[0]));
                compare_field("new_vel_y", EW'(want.vel[1]), EW'(got.vel[1]));
                compare_field("new_vel_z", EW'(want.vel[2]), EW'(got.vel[2]));
                compare_field("new_pos_x", EW'(want.pos[0]), EW'(got.pos[0]));
                compare_field("new_pos_y", EW'(want.pos[1]), EW'(got.pos[1]));
                compare_field("new_pos_z", EW'(want.pos[2]), EW'(got.pos[2]));
                compare_field("kinetic_energy", want.energy, got.energy);
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_time_step_limits();
        test_velocity_cap_limits();
        test_energy_sum_restart();
        test_output_backpressure();
        test_random_traffic();
        wait_results_drained();
        repeat (150) @(posedge aclk);
        if (error_count == 0 && pending_updates.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
